### sv/fnvlp_pkg.sv
// Package for the FNV-1a keyed linear probing hash table.
// Holds default sizes, hash constants, command/status/state codes and the node record layout.
// No dependencies.
package fnvlp_pkg;

	localparam int unsigned NODE_CAPACITY_DEF = 1024;
	localparam int unsigned SLOT_COUNT_DEF    = 2048;
	localparam int unsigned KEY_BYTES_DEF     = 20;

	// A stored key always holds the full twenty bytes.
	localparam int unsigned KEY_STORE = 20;
	localparam int unsigned KEY_W     = 8 * KEY_STORE;

	localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
	localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

	localparam logic [10:0] NODE_LIMIT_RST = 11'd1024;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HASH,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_NODE_CHK,
		ST_DONE
	} state_t;

	// One node: the key followed by its payload.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [10:0]      parent;
		logic [6:0]       depth;
		logic [7:0]       tag_a;
		logic [7:0]       tag_b;
	} node_rec_t;

endpackage

### sv/fnvlp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the slot table and the node store. No dependencies.
module fnvlp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/fnv_linear_probe_hash_table.sv
// Top level of the FNV-1a keyed open addressing hash table with linear probing.
// Depends on fnvlp_pkg and fnvlp_ram.

// Usage notes. A request is taken at a clock edge where start is high and busy is low; its
// single result appears for exactly one cycle with done high and cannot be held off, so the
// receiver must capture it then. The key is hashed one byte per cycle through a rotating
// shift register for every lookup or insert. The probe walk then reads the slot table and,
// for a lookup, the node store, each through a RAM with a registered read port: a lookup
// passes through the slot read, slot check and key compare states on every occupied slot
// it examines and through the slot read and slot check on the empty slot that ends a miss,
// while an insert passes through the slot read and slot check on every slot it visits.
// The next request can be taken in the cycle after done. An insert that finds the table
// full, and the unused command code, answer in the very next cycle. Clear, and reset,
// sweep the slot table one entry a cycle, so both keep busy high until all SLOT_COUNT
// slots (2048 by default) have been emptied; clear then reports its result. SLOT_COUNT
// must be a power of two, since the slot number is the low bits of the hash. The node
// limit register may be written at any time the block is idle; its write channel is
// always ready.
module fnv_linear_probe_hash_table import fnvlp_pkg::*; #(
	parameter int unsigned NODE_CAPACITY = NODE_CAPACITY_DEF,
	parameter int unsigned SLOT_COUNT    = SLOT_COUNT_DEF,
	parameter int unsigned KEY_BYTES     = KEY_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Request channel
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [63:0]        key_lo,
	input  logic [63:0]        key_mid,
	input  logic [31:0]        key_hi,
	input  logic signed [10:0] parent_in,
	input  logic [6:0]         depth_in,
	input  logic [7:0]         tag_first,
	input  logic [7:0]         tag_second,
	// Node limit register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [10:0]        node_limit,
	// Result channel
	output logic               done,
	output logic [1:0]         status,
	output logic [9:0]         node_index,
	output logic signed [10:0] parent_out,
	output logic [6:0]         depth_out,
	output logic [7:0]         tag_first_out,
	output logic [7:0]         tag_second_out
);

	localparam int unsigned SW  = $clog2(SLOT_COUNT);
	localparam int unsigned NW  = $clog2(NODE_CAPACITY);
	localparam int unsigned CW  = $clog2(NODE_CAPACITY + 1);
	localparam int unsigned KCW = $clog2(KEY_STORE);

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (8 * (KEY_STORE - KEY_BYTES));
	// Only the low SW bits of the hash matter, and the low bits of a product depend only
	// on the low bits of its factors, so the hash register is just SW bits wide.
	localparam logic [SW-1:0]  HASH_INIT  = FNV_BASIS[SW-1:0];
	localparam logic [SW-1:0]  PRIME_LO   = FNV_PRIME[SW-1:0];
	localparam logic [SW-1:0]  SLOT_LAST  = SW'(SLOT_COUNT - 1);
	localparam logic [KCW-1:0] KEY_LAST   = KCW'(KEY_STORE - 1);
	localparam logic [KCW-1:0] KEY_HASHED = KCW'(KEY_BYTES);

	// Control state
	state_t      state_q, state_d;
	cmd_t        cmd_q;
	logic [SW-1:0] sweep_q;
	logic [CW-1:0] node_count_q;
	logic [10:0]   node_limit_q;

	// Working registers of the current request
	logic [KEY_W-1:0] key_q;
	logic [10:0]      parent_q;
	logic [6:0]       depth_q;
	logic [7:0]       tag_a_q;
	logic [7:0]       tag_b_q;
	logic [KCW-1:0]   ctr_q;
	logic [SW-1:0]    hash_q;
	logic [SW-1:0]    slot_q;
	logic [SW-1:0]    probe_q;
	logic [NW-1:0]    id_q;
	logic [NW-1:0]    new_idx_q;

	// Result registers
	status_t     res_status_q;
	logic [9:0]  res_index_q;
	logic [10:0] res_parent_q;
	logic [6:0]  res_depth_q;
	logic [7:0]  res_tag_a_q;
	logic [7:0]  res_tag_b_q;

	// Memory ports
	logic          slot_we;
	logic [SW-1:0] slot_waddr;
	logic [CW-1:0] slot_wdata;
	logic [CW-1:0] slot_rdata;
	logic          node_we;
	node_rec_t     node_wdata;
	node_rec_t     node_rdata;
	logic [NW-1:0] node_raddr;

	logic          accept;
	cmd_t          cmd_in;
	logic          full_now;
	logic          slot_empty;
	logic          key_hit;
	logic [SW-1:0] hash_x;
	logic [SW-1:0] hash_mul;
	logic [SW-1:0] hash_step;

	assign accept = start && (state_q == ST_IDLE);
	assign cmd_in = cmd_t'(command);

	// The effective limit is the smallest of the register, the node store and the slot
	// table, so a successful insert always finds an empty slot.
	assign full_now = (32'(node_count_q) >= 32'(node_limit_q)) ||
	                  (32'(node_count_q) >= NODE_CAPACITY) ||
	                  (32'(node_count_q) >= SLOT_COUNT);

	// One FNV-1a round per cycle on the byte at the bottom of the rotating key register.
	// Bytes past KEY_BYTES still rotate through so that the key returns to its place.
	assign hash_x    = hash_q ^ SW'(key_q[7:0]);
	assign hash_mul  = hash_x * PRIME_LO;
	assign hash_step = (ctr_q < KEY_HASHED) ? hash_mul : hash_q;

	// Slot entries hold node index plus one, zero meaning empty.
	assign slot_empty = (slot_rdata == '0);
	assign node_raddr = NW'(slot_rdata - CW'(1));
	assign key_hit    = (((node_rdata.key ^ key_q) & KEY_MASK) == '0);

	assign node_wdata = '{key: key_q, parent: parent_q, depth: depth_q,
	                      tag_a: tag_a_q, tag_b: tag_b_q};

	fnvlp_ram #(
		.WIDTH(CW),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_q),
		.rdata(slot_rdata)
	);

	fnvlp_ram #(
		.WIDTH($bits(node_rec_t)),
		.DEPTH(NODE_CAPACITY)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(new_idx_q),
		.wdata(node_wdata),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory write controls.
	always_comb begin
		state_d    = state_q;
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = '0;
		node_we    = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				slot_we    = 1'b1;
				slot_waddr = sweep_q;
				if (sweep_q == SLOT_LAST) begin
					state_d = (cmd_q == CMD_CLEAR) ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd_in)
						CMD_LOOKUP: state_d = ST_HASH;
						CMD_INSERT: state_d = full_now ? ST_DONE : ST_HASH;
						CMD_CLEAR:  state_d = ST_SWEEP;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_HASH: begin
				// The key register is still in place on the first hash cycle.
				if ((cmd_q == CMD_INSERT) && (ctr_q == '0)) begin
					node_we = 1'b1;
				end
				if (ctr_q == KEY_LAST) begin
					state_d = ST_SLOT_RD;
				end
			end
			ST_SLOT_RD: begin
				state_d = ST_SLOT_CHK;
			end
			ST_SLOT_CHK: begin
				if (slot_empty) begin
					if (cmd_q == CMD_INSERT) begin
						slot_we    = 1'b1;
						slot_wdata = CW'(new_idx_q) + CW'(1);
					end
					state_d = ST_DONE;
				end else if (cmd_q == CMD_INSERT) begin
					state_d = ST_SLOT_RD;
				end else begin
					state_d = ST_NODE_CHK;
				end
			end
			ST_NODE_CHK: begin
				// A lookup gives up after examining every slot once.
				if (key_hit || (probe_q == SLOT_LAST)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SLOT_RD;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= '0;
			cmd_q        <= CMD_LOOKUP;
			node_count_q <= '0;
			node_limit_q <= NODE_LIMIT_RST;
		end else begin
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + SW'(1);
			end
			if (cfg_valid) begin
				node_limit_q <= node_limit;
			end
			if (accept) begin
				cmd_q <= cmd_in;
				if ((cmd_in == CMD_INSERT) && !full_now) begin
					node_count_q <= node_count_q + CW'(1);
				end
				if (cmd_in == CMD_CLEAR) begin
					node_count_q <= '0;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= {key_hi, key_mid, key_lo};
			parent_q  <= parent_in;
			depth_q   <= depth_in;
			tag_a_q   <= tag_first;
			tag_b_q   <= tag_second;
			hash_q    <= HASH_INIT;
			ctr_q     <= '0;
			probe_q   <= '0;
			new_idx_q <= NW'(node_count_q);
			res_index_q  <= '0;
			res_parent_q <= '0;
			res_depth_q  <= '0;
			res_tag_a_q  <= '0;
			res_tag_b_q  <= '0;
			case (cmd_in)
				CMD_LOOKUP: res_status_q <= STAT_MISS;
				CMD_INSERT: begin
					if (full_now) begin
						res_status_q <= STAT_FULL;
					end else begin
						res_status_q <= STAT_OK;
						res_index_q  <= 10'(node_count_q);
					end
				end
				CMD_CLEAR:  res_status_q <= STAT_OK;
				default:    res_status_q <= STAT_MISS;
			endcase
		end
		if (state_q == ST_HASH) begin
			key_q  <= {key_q[7:0], key_q[KEY_W-1:8]};
			hash_q <= hash_step;
			ctr_q  <= ctr_q + KCW'(1);
			if (ctr_q == KEY_LAST) begin
				slot_q <= hash_step;
			end
		end
		if (state_q == ST_SLOT_CHK) begin
			id_q <= node_raddr;
			if (!slot_empty && (cmd_q == CMD_INSERT)) begin
				slot_q <= slot_q + SW'(1);
			end
		end
		if (state_q == ST_NODE_CHK) begin
			if (key_hit) begin
				res_status_q <= STAT_OK;
				res_index_q  <= 10'(id_q);
				res_parent_q <= node_rdata.parent;
				res_depth_q  <= node_rdata.depth;
				res_tag_a_q  <= node_rdata.tag_a;
				res_tag_b_q  <= node_rdata.tag_b;
			end else begin
				slot_q  <= slot_q + SW'(1);
				probe_q <= probe_q + SW'(1);
			end
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign done           = (state_q == ST_DONE);
	assign status         = res_status_q;
	assign node_index     = res_index_q;
	assign parent_out     = res_parent_q;
	assign depth_out      = res_depth_q;
	assign tag_first_out  = res_tag_a_q;
	assign tag_second_out = res_tag_b_q;

	// A result strobe never lasts more than one cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// Every accepted request keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block idle right after taking a request");

	// The node count never passes the node store size.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(node_count_q) <= NODE_CAPACITY)
		else $error("node count beyond capacity");

	// Only a lookup compares stored keys.
	a_node_chk_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NODE_CHK) |-> (cmd_q == CMD_LOOKUP))
		else $error("key compare outside a lookup");

endmodule

### verif/fnvlp_checker.sv
`timescale 1ns / 100ps
// Checker for the FNV-1a keyed linear probing hash table. It keeps its own copy of the slot
// table and node store, predicts every answer and compares it with the answer reported.
// Depends on fnvlp_pkg.
module fnvlp_checker import fnvlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         command,
	input  logic [63:0]        key_lo,
	input  logic [63:0]        key_mid,
	input  logic [31:0]        key_hi,
	input  logic signed [10:0] parent_in,
	input  logic [6:0]         depth_in,
	input  logic [7:0]         tag_first,
	input  logic [7:0]         tag_second,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [10:0]        node_limit,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [9:0]         node_index,
	input  logic signed [10:0] parent_out,
	input  logic [6:0]         depth_out,
	input  logic [7:0]         tag_first_out,
	input  logic [7:0]         tag_second_out,
	output int                 fail_count,
	output int                 waiting,
	output int                 lookups_seen,
	output int                 hits_seen,
	output int                 inserts_seen,
	output int                 fulls_seen,
	output int                 clears_seen
);

	localparam int unsigned NODES = NODE_CAPACITY_DEF;
	localparam int unsigned SLOTS = SLOT_COUNT_DEF;
	localparam int REPORT_CAP = 100;

	typedef struct packed {
		status_t     status;
		logic [9:0]  node_index;
		logic [10:0] parent;
		logic [6:0]  depth;
		logic [7:0]  tag_a;
		logic [7:0]  tag_b;
	} table_answer_t;

	table_answer_t answers_due[$];

	// Slot entries hold node index plus one; zero marks an empty slot.
	logic [10:0]      slot_ref [SLOTS];
	logic [KEY_W-1:0] key_ref [NODES];
	logic [10:0]      parent_ref [NODES];
	logic [6:0]       depth_ref [NODES];
	logic [7:0]       tag_a_ref [NODES];
	logic [7:0]       tag_b_ref [NODES];
	int unsigned      count_ref;
	logic [10:0]      limit_ref;
	int unsigned      sweep;

	function automatic int unsigned fnv_home_slot(input logic [KEY_W-1:0] key);
		logic [63:0] h;
		int unsigned i;
		h = FNV_BASIS;
		for (i = 0; i < KEY_BYTES_DEF; i++) begin
			h = h ^ {56'd0, key[8*i +: 8]};
			h = h * FNV_PRIME;
		end
		return int'(h % SLOTS);
	endfunction

	function automatic table_answer_t predict_table_answer(input logic [1:0] cmd,
			input logic [KEY_W-1:0] key, input logic [10:0] parent, input logic [6:0] depth,
			input logic [7:0] tag_a, input logic [7:0] tag_b);
		table_answer_t ans;
		int unsigned slot;
		int unsigned probes;
		int unsigned cap;
		logic [10:0] entry;
		ans = '0;
		ans.status = STAT_MISS;
		case (cmd)
			CMD_LOOKUP: begin
				lookups_seen++;
				slot = fnv_home_slot(key);
				for (probes = 0; probes < SLOTS; probes++) begin
					entry = slot_ref[slot];
					if (entry == '0)
						break;
					if (key_ref[entry - 11'd1] == key) begin
						ans.status     = STAT_OK;
						ans.node_index = 10'(entry - 11'd1);
						ans.parent     = parent_ref[entry - 11'd1];
						ans.depth      = depth_ref[entry - 11'd1];
						ans.tag_a      = tag_a_ref[entry - 11'd1];
						ans.tag_b      = tag_b_ref[entry - 11'd1];
						hits_seen++;
						break;
					end
					slot = (slot + 1) % SLOTS;
				end
			end
			CMD_INSERT: begin
				cap = limit_ref;
				if (cap > NODES)
					cap = NODES;
				if (cap > SLOTS)
					cap = SLOTS;
				if (count_ref >= cap) begin
					ans.status = STAT_FULL;
					fulls_seen++;
				end else begin
					key_ref[count_ref]    = key;
					parent_ref[count_ref] = parent;
					depth_ref[count_ref]  = depth;
					tag_a_ref[count_ref]  = tag_a;
					tag_b_ref[count_ref]  = tag_b;
					slot = fnv_home_slot(key);
					for (probes = 0; probes < SLOTS; probes++) begin
						if (slot_ref[slot] == '0) begin
							slot_ref[slot] = 11'(count_ref + 1);
							break;
						end
						slot = (slot + 1) % SLOTS;
					end
					ans.status     = STAT_OK;
					ans.node_index = 10'(count_ref);
					count_ref++;
					inserts_seen++;
				end
			end
			CMD_CLEAR: begin
				for (probes = 0; probes < SLOTS; probes++)
					slot_ref[probes] = '0;
				count_ref = 0;
				ans.status = STAT_OK;
				clears_seen++;
			end
			default: begin
				// The unused code changes nothing and answers as a miss.
			end
		endcase
		return ans;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= REPORT_CAP)
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			else if (fail_count == REPORT_CAP + 1)
				$display("Further mismatches are counted but not printed.");
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (sweep = 0; sweep < SLOTS; sweep++)
				slot_ref[sweep] = '0;
			count_ref    = 0;
			limit_ref    = NODE_LIMIT_RST;
			answers_due.delete();
			fail_count   = 0;
			lookups_seen = 0;
			hits_seen    = 0;
			inserts_seen = 0;
			fulls_seen   = 0;
			clears_seen  = 0;
		end else begin
			if (done) begin
				if (answers_due.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected answer, expected none, got status %0d index %0d",
						$time, status, node_index);
				end else begin
					table_answer_t want;
					want = answers_due.pop_front();
					check_field("status", {62'd0, want.status}, {62'd0, status});
					check_field("node_index", {54'd0, want.node_index}, {54'd0, node_index});
					check_field("parent_out", {53'd0, want.parent}, {53'd0, parent_out});
					check_field("depth_out", {57'd0, want.depth}, {57'd0, depth_out});
					check_field("tag_first_out", {56'd0, want.tag_a}, {56'd0, tag_first_out});
					check_field("tag_second_out", {56'd0, want.tag_b}, {56'd0, tag_second_out});
				end
			end
			if (cfg_valid && cfg_ready)
				limit_ref = node_limit;
			if (start && !busy)
				answers_due.push_back(predict_table_answer(command,
					{key_hi, key_mid, key_lo}, parent_in, depth_in, tag_first, tag_second));
		end
		waiting = answers_due.size();
	end

endmodule

### verif/fnv_linear_probe_hash_table_test.sv
`timescale 1ns / 100ps
// Top level of the hash table testbench: clock, reset, directed and random requests, and the
// verdict. Depends on fnvlp_pkg, fnv_linear_probe_hash_table and fnvlp_checker.
module fnv_linear_probe_hash_table_test import fnvlp_pkg::*; ();

	localparam int CLK_HALF     = 4;
	// The slowest correct run stays well below this limit: one full sweep of the slot table
	// per clear, the hashing of every request, short probe chains and random sender gaps.
	localparam int CYCLE_LIMIT  = 1000000;
	// Every request answers, so only a short quiet period is needed at the end.
	localparam int DRAIN_CYCLES = 40;
	// The one command code that the package leaves unnamed.
	localparam logic [1:0] CMD_RESERVED = 2'd3;
	localparam int unsigned CAPACITY = NODE_CAPACITY_DEF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         command = CMD_LOOKUP;
	logic [63:0]        key_lo = '0;
	logic [63:0]        key_mid = '0;
	logic [31:0]        key_hi = '0;
	logic signed [10:0] parent_in = '0;
	logic [6:0]         depth_in = '0;
	logic [7:0]         tag_first = '0;
	logic [7:0]         tag_second = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [10:0]        node_limit = '0;
	logic               done;
	logic [1:0]         status;
	logic [9:0]         node_index;
	logic signed [10:0] parent_out;
	logic [6:0]         depth_out;
	logic [7:0]         tag_first_out;
	logic [7:0]         tag_second_out;

	int fail_count;
	int waiting;
	int lookups_seen;
	int hits_seen;
	int inserts_seen;
	int fulls_seen;
	int clears_seen;

	// Keys that went into the table since the last clear. Lookups draw on these so that most
	// of them walk a real probe chain and end in a hit.
	logic [KEY_W-1:0] known_keys[$];
	int unsigned      nodes_sent = 0;
	logic [10:0]      limit_now = NODE_LIMIT_RST;
	int               idle_pct = 0;
	int               limit_writes = 0;
	// Tracks whether start is being held high, so that it is never lowered twice in a step.
	bit               holding = 1'b0;

	fnv_linear_probe_hash_table dut (.*);

	fnvlp_checker checker_inst (.*);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Watchdog: if the run has not finished by now, something is hung.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** fnv_linear_probe_hash_table: FAILED **");
		$finish;
	end

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// Presents one request at the falling edge and holds it until the block takes it, that is
	// until a rising edge at which busy is low. Returns at the next falling edge, and then
	// leaves the request channel quiet for a while if the current idling phase says so.
	task automatic issue(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
			input logic [10:0] parent, input logic [6:0] depth, input logic [7:0] tag_a,
			input logic [7:0] tag_b);
		int unsigned cap;
		if (!holding) begin
			start <= 1'b1;
			holding = 1'b1;
		end
		command    <= cmd;
		key_lo     <= key[63:0];
		key_mid    <= key[127:64];
		key_hi     <= key[159:128];
		parent_in  <= parent;
		depth_in   <= depth;
		tag_first  <= tag_a;
		tag_second <= tag_b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		// Keep the list of stored keys in step with what the table should now hold.
		cap = limit_now;
		if (cap > CAPACITY)
			cap = CAPACITY;
		if (cmd == CMD_INSERT && nodes_sent < cap) begin
			known_keys.push_back(key);
			nodes_sent++;
		end else if (cmd == CMD_CLEAR) begin
			known_keys.delete();
			nodes_sent = 0;
		end
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			holding = 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	endtask

	// Stops issuing and waits until every answer has arrived and the block is idle. This also
	// covers the slot table sweep that follows reset.
	task automatic settle();
		if (holding) begin
			start <= 1'b0;
			holding = 1'b0;
		end
		@(negedge clk);
		while (waiting != 0 || busy)
			@(negedge clk);
	endtask

	// Writes the node limit register while the block is idle.
	task automatic set_limit(input logic [10:0] value);
		settle();
		cfg_valid  <= 1'b1;
		node_limit <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		limit_now = value;
		limit_writes++;
	endtask

	// One random phase: a limit setting, an idling pattern and a mix of requests. Most of the
	// mix is inserts of fresh keys and lookups of stored ones; the rest are misses, keys one
	// bit away from a stored key, duplicate inserts, the unused code and the odd clear.
	task automatic run_phase(input logic [10:0] limit_value, input int pct, input int items);
		int               pick;
		logic [KEY_W-1:0] key;
		logic [1:0]       cmd;
		logic [10:0]      parent;
		logic [6:0]       depth;
		logic [7:0]       tag_a;
		logic [7:0]       tag_b;
		set_limit(limit_value);
		idle_pct = pct;
		repeat (items) begin
			pick   = $urandom_range(99);
			key    = random_key();
			parent = 11'($urandom_range(1024)) - 11'd1;
			depth  = 7'($urandom_range(64));
			tag_a  = 8'($urandom_range(255));
			tag_b  = 8'($urandom_range(255));
			if (pick < 42) begin
				cmd = CMD_LOOKUP;
				if (known_keys.size() != 0)
					key = known_keys[$urandom_range(known_keys.size() - 1)];
			end else if (pick < 54) begin
				cmd = CMD_LOOKUP;
			end else if (pick < 58) begin
				cmd = CMD_LOOKUP;
				if (known_keys.size() != 0)
					key = known_keys[$urandom_range(known_keys.size() - 1)]
						^ (160'd1 << $urandom_range(KEY_W - 1));
			end else if (pick < 90) begin
				cmd = CMD_INSERT;
			end else if (pick < 96) begin
				// Same key again: a second node is added behind the first on the probe path.
				cmd = CMD_INSERT;
				if (known_keys.size() != 0)
					key = known_keys[$urandom_range(known_keys.size() - 1)];
			end else if (pick < 99) begin
				cmd = CMD_RESERVED;
			end else begin
				cmd = CMD_CLEAR;
			end
			issue(cmd, key, parent, depth, tag_a, tag_b);
		end
	endtask

	initial begin
		// Reset is held low from time zero and released at a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// A limit of zero refuses every insert, and an empty table misses every lookup.
		set_limit(11'd0);
		issue(CMD_INSERT, '0, 11'h7ff, 7'd64, 8'hff, 8'h00);
		issue(CMD_LOOKUP, '0, '0, '0, '0, '0);
		issue(CMD_RESERVED, '1, 11'h7ff, 7'h7f, 8'hff, 8'hff);

		// A limit of one takes a single node, stored with the root parent and the extreme
		// payload values, then reports full.
		set_limit(11'd1);
		issue(CMD_INSERT, '0, 11'h7ff, 7'd64, 8'hff, 8'h00);
		issue(CMD_INSERT, '1, 11'd1023, 7'd0, 8'h00, 8'hff);
		issue(CMD_LOOKUP, '0, '0, '0, '0, '0);
		issue(CMD_LOOKUP, '1, '0, '0, '0, '0);

		// A limit above capacity. The duplicate of the all-zero key lands further down the
		// probe path, so a lookup still returns the first node. Clear empties the table and
		// restarts node numbering from zero.
		set_limit(11'd2047);
		issue(CMD_INSERT, '1, 11'd1023, 7'd0, 8'h00, 8'hff);
		issue(CMD_INSERT, '0, 11'd0, 7'd1, 8'h01, 8'h02);
		issue(CMD_LOOKUP, '0, '1, '1, '1, '1);
		issue(CMD_LOOKUP, '1, '0, '0, '0, '0);
		issue(CMD_RESERVED, '0, '0, '0, '0, '0);
		issue(CMD_CLEAR, '1, '1, '1, '1, '1);
		issue(CMD_LOOKUP, '0, '0, '0, '0, '0);
		issue(CMD_INSERT, '1, 11'h400, 7'h3f, 8'h80, 8'h7f);
		issue(CMD_LOOKUP, '1, '0, '0, '0, '0);

		// Random phases over several limit settings and idling patterns. A limit lowered below
		// the current node count makes every insert report full while stored keys still hit.
		run_phase(11'd2047, 0, 230);
		run_phase(11'd1024, 63, 200);
		run_phase(11'($urandom_range(2, 40)), 21, 180);
		run_phase(11'd1, 63, 100);
		run_phase(11'd0, 0, 60);
		run_phase(11'($urandom_range(1, 2047)), 21, 180);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d lookups (%0d hits), %0d inserts stored, %0d refused as full,",
			lookups_seen, hits_seen, inserts_seen, fulls_seen);
		$display("and %0d clears, across %0d node limit settings and three idling patterns.",
			clears_seen, limit_writes);
		if (fail_count == 0) begin
			$display("** fnv_linear_probe_hash_table: PASSED **");
		end else begin
			$display("** fnv_linear_probe_hash_table: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
sv/fnvlp_pkg.sv
sv/fnvlp_ram.sv
sv/fnv_linear_probe_hash_table.sv
verif/fnvlp_checker.sv
verif/fnv_linear_probe_hash_table_test.sv
